/* hdl/skt_pkg.sv */
package skt_pkg;

    localparam int CAPACITY   = 16;
    localparam int KEY_WIDTH  = 32;
    localparam int IDX_W      = $clog2(CAPACITY);
    localparam int CNT_W      = $clog2(CAPACITY + 1);
    localparam int MODE_W     = 3;
    localparam int STATUS_W   = 3;
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    // register index, taken from the word address bit
    localparam logic REG_DESC_ORDER = 1'b0;

    typedef enum logic [MODE_W-1:0] {
        MODE_INSERT = 3'd0,
        MODE_REMOVE = 3'd1,
        MODE_REWIND = 3'd2,
        MODE_NEXT   = 3'd3,
        MODE_PEEK   = 3'd4
    } mode_t;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_DONE     = 3'd0,
        STATUS_DUP      = 3'd1,
        STATUS_FULL     = 3'd2,
        STATUS_NOTFOUND = 3'd3,
        STATUS_END      = 3'd4
    } status_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SCAN_RD,
        S_SCAN_CMP,
        S_SHIFT_RD,
        S_SHIFT_WR,
        S_PLACE,
        S_READ_RD,
        S_READ_CMP,
        S_FINISH
    } state_t;

endpackage

/* hdl/sorted_key_table_unit.sv */
// Sorted key table: holds up to CAPACITY unique keys in a single-port-read,
// single-port-write table, kept in descending order (or ascending when the
// order register at address 0 is cleared; write it only while idle). Each
// input transaction carries one operation and gives exactly one result
// transaction with status, key and live count. One comparator and the table
// memory are reused step by step, and the scan reads one slot per pass through
// a read step and a compare step, through the registered memory read. Rewind
// and unused modes go straight to the result; next and peek read one slot and
// take it, or stop at the end of the list. An insert that finds no duplicate
// scans the whole table, because a duplicate can sit past the insertion point
// once the order register has been changed, then moves the keys behind the
// insertion point one slot at a time and places the key. A remove scans up to
// the key and moves the keys behind it one slot forward; a duplicate insert
// stops at the duplicate. The longest case is an insert ahead of CAPACITY-1 keys. s_ready is high only between
// transactions; a finished result waits in the output register while the next
// transaction is taken, and a stalled result register holds the sequencer in
// its last step.
module sorted_key_table_unit (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [skt_pkg::MODE_W-1:0]          s_mode,
    input  logic [skt_pkg::KEY_WIDTH-1:0]       s_key,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [skt_pkg::STATUS_W-1:0]        m_status,
    output logic [skt_pkg::KEY_WIDTH-1:0]       m_item,
    output logic [skt_pkg::CNT_W-1:0]           m_count,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [skt_pkg::APB_ADDR_W-1:0]      paddr,
    input  logic [skt_pkg::APB_DATA_W-1:0]      pwdata,
    output logic [skt_pkg::APB_DATA_W-1:0]      prdata,
    output logic                                pready
);
    import skt_pkg::*;

    state_t                 state_reg, state_next;
    mode_t                  mode_reg;
    logic [KEY_WIDTH-1:0]   key_reg;
    logic [CNT_W-1:0]       idx_reg, idx_next;
    logic [CNT_W-1:0]       pos_reg, pos_next;
    logic [CNT_W-1:0]       fill_reg, fill_next;
    logic [CNT_W-1:0]       rpos_reg, rpos_next;
    logic                   desc_reg;
    status_t                res_status_reg, res_status_next;
    logic [KEY_WIDTH-1:0]   res_item_reg, res_item_next;
    logic                   m_valid_reg;
    status_t                m_status_reg;
    logic [KEY_WIDTH-1:0]   m_item_reg;
    logic [CNT_W-1:0]       m_count_reg;

    logic [KEY_WIDTH-1:0]   entries_mem [CAPACITY];
    logic [KEY_WIDTH-1:0]   rd_data_reg;
    logic [IDX_W-1:0]       rd_addr;
    logic                   wr_en;
    logic [IDX_W-1:0]       wr_addr;
    logic [KEY_WIDTH-1:0]   wr_data;

    logic                   in_fire, out_free, cfg_wr;
    logic                   key_eq, key_before, full;
    logic                   is_insert;
    logic [CNT_W-1:0]       idx_inc, idx_dec;

    // configuration
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_DESC_ORDER);
    assign prdata = (paddr[2] == REG_DESC_ORDER) ? APB_DATA_W'(desc_reg) : '0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            desc_reg <= 1'b1;
        end else if (cfg_wr) begin
            desc_reg <= pwdata[0];
        end
    end

    // handshakes
    assign s_ready  = (state_reg == S_IDLE);
    assign in_fire  = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;

    // shared compare unit
    assign key_eq     = (rd_data_reg == key_reg);
    assign key_before = desc_reg ? (key_reg > rd_data_reg) : (key_reg < rd_data_reg);
    assign full       = (fill_reg == CNT_W'(CAPACITY));
    assign is_insert  = (mode_reg == MODE_INSERT);
    assign idx_inc    = idx_reg + 1'b1;
    assign idx_dec    = idx_reg - 1'b1;

    // table memory, registered read
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            entries_mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= entries_mem[rd_addr];
    end

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: begin
                if (in_fire) begin
                    case (mode_t'(s_mode))
                        MODE_INSERT, MODE_REMOVE: state_next = S_SCAN_RD;
                        MODE_NEXT, MODE_PEEK:     state_next = S_READ_RD;
                        default:                  state_next = S_FINISH;
                    endcase
                end
            end
            S_SCAN_RD: begin
                if (idx_reg == fill_reg) begin
                    if (!is_insert || full) begin
                        state_next = S_FINISH;
                    end else if (pos_reg == fill_reg) begin
                        state_next = S_PLACE;
                    end else begin
                        state_next = S_SHIFT_RD;
                    end
                end else begin
                    state_next = S_SCAN_CMP;
                end
            end
            S_SCAN_CMP: begin
                if (key_eq) begin
                    state_next = is_insert ? S_FINISH : S_SHIFT_RD;
                end else begin
                    state_next = S_SCAN_RD;
                end
            end
            S_SHIFT_RD: begin
                if (is_insert) begin
                    state_next = (idx_reg == pos_reg) ? S_PLACE : S_SHIFT_WR;
                end else begin
                    state_next = (idx_inc >= fill_reg) ? S_FINISH : S_SHIFT_WR;
                end
            end
            S_SHIFT_WR: state_next = S_SHIFT_RD;
            S_PLACE:    state_next = S_FINISH;
            S_READ_RD:  state_next = (rpos_reg >= fill_reg) ? S_FINISH : S_READ_CMP;
            S_READ_CMP: state_next = S_FINISH;
            S_FINISH:   state_next = out_free ? S_IDLE : S_FINISH;
            default:    state_next = S_IDLE;
        endcase
    end

    // datapath and memory control
    always_comb begin
        idx_next        = idx_reg;
        pos_next        = pos_reg;
        fill_next       = fill_reg;
        rpos_next       = rpos_reg;
        res_status_next = res_status_reg;
        res_item_next   = res_item_reg;
        rd_addr         = '0;
        wr_en           = 1'b0;
        wr_addr         = idx_reg[IDX_W-1:0];
        wr_data         = rd_data_reg;
        case (state_reg)
            S_IDLE: begin
                if (in_fire) begin
                    idx_next        = '0;
                    pos_next        = fill_reg;
                    res_status_next = STATUS_DONE;
                    res_item_next   = '0;
                    if (mode_t'(s_mode) == MODE_REWIND) begin
                        rpos_next = '0;
                    end
                end
            end
            S_SCAN_RD: begin
                if (idx_reg == fill_reg) begin
                    if (!is_insert) begin
                        res_status_next = STATUS_NOTFOUND;
                    end else if (full) begin
                        res_status_next = STATUS_FULL;
                    end
                end else begin
                    rd_addr = idx_reg[IDX_W-1:0];
                end
            end
            S_SCAN_CMP: begin
                if (key_eq) begin
                    if (is_insert) begin
                        res_status_next = STATUS_DUP;
                    end
                end else begin
                    // keep the first slot the key goes ahead of, scan on for a duplicate
                    if (is_insert && key_before && pos_reg == fill_reg) begin
                        pos_next = idx_reg;
                    end
                    idx_next = idx_inc;
                end
            end
            S_SHIFT_RD: begin
                if (is_insert) begin
                    if (idx_reg != pos_reg) begin
                        rd_addr = idx_dec[IDX_W-1:0];
                    end
                end else if (idx_inc >= fill_reg) begin
                    fill_next     = fill_reg - 1'b1;
                    res_item_next = key_reg;
                end else begin
                    rd_addr = idx_inc[IDX_W-1:0];
                end
            end
            S_SHIFT_WR: begin
                wr_en    = 1'b1;
                idx_next = is_insert ? idx_dec : idx_inc;
            end
            S_PLACE: begin
                wr_en         = 1'b1;
                wr_addr       = pos_reg[IDX_W-1:0];
                wr_data       = key_reg;
                fill_next     = fill_reg + 1'b1;
                res_item_next = key_reg;
            end
            S_READ_RD: begin
                if (rpos_reg >= fill_reg) begin
                    res_status_next = STATUS_END;
                end else begin
                    rd_addr = rpos_reg[IDX_W-1:0];
                end
            end
            S_READ_CMP: begin
                res_item_next = rd_data_reg;
                if (mode_reg == MODE_NEXT) begin
                    rpos_next = rpos_reg + 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            fill_reg  <= '0;
            rpos_reg  <= '0;
        end else begin
            state_reg <= state_next;
            fill_reg  <= fill_next;
            rpos_reg  <= rpos_next;
        end
    end

    // working registers
    always_ff @(posedge aclk) begin
        if (in_fire) begin
            mode_reg <= mode_t'(s_mode);
            key_reg  <= s_key;
        end
        idx_reg        <= idx_next;
        pos_reg        <= pos_next;
        res_status_reg <= res_status_next;
        res_item_reg   <= res_item_next;
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (state_reg == S_FINISH && out_free) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == S_FINISH && out_free) begin
            m_status_reg <= res_status_reg;
            m_item_reg   <= res_item_reg;
            m_count_reg  <= fill_reg;
        end
    end

    assign m_valid  = m_valid_reg;
    assign m_status = m_status_reg;
    assign m_item   = m_item_reg;
    assign m_count  = m_count_reg;

    a_fill_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        fill_reg <= CNT_W'(CAPACITY))
        else $error("fill count above capacity");

    a_no_write_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_IDLE) |-> !wr_en)
        else $error("table written while idle");

    a_item_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_status_reg != STATUS_DONE) |-> (m_item_reg == '0))
        else $error("item not zero on failed operation");

    a_fill_step: assert property (@(posedge aclk) disable iff (!aresetn)
        1'b1 |=> (fill_reg == $past(fill_reg) || fill_reg == $past(fill_reg) + 1'b1
                  || fill_reg == $past(fill_reg) - 1'b1))
        else $error("fill count moved by more than one");

    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        in_fire |=> !s_ready)
        else $error("ready straight after accepting a transaction");

endmodule

/* tb/sorted_key_table_checker.sv */
`timescale 1ns / 1ps

module sorted_key_table_checker (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    input  logic                           s_ready,
    input  logic [skt_pkg::MODE_W-1:0]     s_mode,
    input  logic [skt_pkg::KEY_WIDTH-1:0]  s_key,
    input  logic                           m_valid,
    input  logic                           m_ready,
    input  logic [skt_pkg::STATUS_W-1:0]   m_status,
    input  logic [skt_pkg::KEY_WIDTH-1:0]  m_item,
    input  logic [skt_pkg::CNT_W-1:0]      m_count,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [skt_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [skt_pkg::APB_DATA_W-1:0] pwdata,
    input  logic                           pready,
    output int                             pending,
    output int                             failures
);
    import skt_pkg::*;

    typedef struct packed {
        status_t              status;
        logic [KEY_WIDTH-1:0] item;
        logic [CNT_W-1:0]     count;
    } table_result_t;

    logic [KEY_WIDTH-1:0] slots [CAPACITY];
    int                   fill_cnt;
    int                   read_slot;
    logic                 desc_order;
    table_result_t        awaited_results [$];
    int                   n_predicted;
    int                   n_checked;

    assign pending = n_predicted - n_checked;

    task automatic report_mismatch(input string msg);
        $display("[%0t] mismatch: %s", $time, msg);
        failures++;
    endtask

    // applies one operation to the shadow table and gives the result it must produce
    task automatic update_table(input logic [MODE_W-1:0] op, input logic [KEY_WIDTH-1:0] key,
                                output table_result_t res);
        int  i;
        int  pos;
        bit  hit;
        res.status = STATUS_DONE;
        res.item   = '0;
        case (op)
            MODE_INSERT: begin
                hit = 1'b0;
                for (i = 0; i < fill_cnt; i++)
                    if (slots[i] == key) hit = 1'b1;
                // duplicate wins over full
                if (hit) begin
                    res.status = STATUS_DUP;
                end else if (fill_cnt >= CAPACITY) begin
                    res.status = STATUS_FULL;
                end else begin
                    pos = fill_cnt;
                    // backward scan leaves the first slot the key goes ahead of
                    for (i = fill_cnt - 1; i >= 0; i--)
                        if (desc_order ? (key > slots[i]) : (key < slots[i])) pos = i;
                    for (i = fill_cnt; i > pos; i--)
                        slots[i] = slots[i-1];
                    slots[pos] = key;
                    fill_cnt++;
                    res.item = key;
                end
            end
            MODE_REMOVE: begin
                pos = -1;
                for (i = fill_cnt - 1; i >= 0; i--)
                    if (slots[i] == key) pos = i;
                if (pos < 0) begin
                    res.status = STATUS_NOTFOUND;
                end else begin
                    for (i = pos; i + 1 < fill_cnt; i++)
                        slots[i] = slots[i+1];
                    fill_cnt--;
                    res.item = key;
                end
            end
            MODE_REWIND: read_slot = 0;
            MODE_NEXT, MODE_PEEK: begin
                // read position is a raw slot index, never adjusted on insert/remove
                if (read_slot >= fill_cnt) begin
                    res.status = STATUS_END;
                end else begin
                    res.item = slots[read_slot];
                    if (op == MODE_NEXT) read_slot++;
                end
            end
            default: ;
        endcase
        res.count = fill_cnt[CNT_W-1:0];
    endtask

    always @(posedge aclk) begin
        table_result_t want;
        if (!aresetn) begin
            fill_cnt    = 0;
            read_slot   = 0;
            desc_order  = 1'b1;
            n_predicted = 0;
            n_checked   = 0;
            awaited_results.delete();
        end else begin
            if (psel && penable && pwrite && pready
                    && paddr[APB_ADDR_W-1:2] == REG_DESC_ORDER)
                desc_order = pwdata[0];

            // result side first: a transaction accepted this edge cannot answer this edge
            if (m_valid && m_ready) begin
                if (awaited_results.size() == 0) begin
                    report_mismatch($sformatf("result with no transaction pending: status %0d item %h count %0d",
                                              m_status, m_item, m_count));
                end else begin
                    want = awaited_results.pop_front();
                    n_checked++;
                    if (m_status !== want.status)
                        report_mismatch($sformatf("status got %0d want %0d", m_status, want.status));
                    if (m_item !== want.item)
                        report_mismatch($sformatf("item got %h want %h", m_item, want.item));
                    if (m_count !== want.count)
                        report_mismatch($sformatf("count got %0d want %0d", m_count, want.count));
                end
            end

            if (s_valid && s_ready) begin
                update_table(s_mode, s_key, want);
                awaited_results.push_back(want);
                n_predicted++;
            end
        end
    end

endmodule

/* tb/tb_sorted_key_table_unit.sv */
`timescale 1ns / 1ps

module tb_sorted_key_table_unit;
    import skt_pkg::*;

    localparam logic [MODE_W-1:0] MODE_SPARE_FIRST = 3'd5;
    localparam logic [MODE_W-1:0] MODE_SPARE_LAST  = 3'd7;
    localparam int PHASES   = 11;
    localparam int POOL_MAX = 24;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  s_valid = 1'b0;
    logic                  s_ready;
    logic [MODE_W-1:0]     s_mode = '0;
    logic [KEY_WIDTH-1:0]  s_key = '0;
    logic                  m_valid;
    logic                  m_ready;
    logic [STATUS_W-1:0]   m_status;
    logic [KEY_WIDTH-1:0]  m_item;
    logic [CNT_W-1:0]      m_count;
    logic                  psel = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite = 1'b0;
    logic [APB_ADDR_W-1:0] paddr = '0;
    logic [APB_DATA_W-1:0] pwdata = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;
    int                    pending;
    int                    failures;
    bit                    calm = 1'b0;
    logic [KEY_WIDTH-1:0]  key_pool [POOL_MAX];
    int                    pool_size = 1;

    sorted_key_table_unit uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_mode   (s_mode),
        .s_key    (s_key),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_status (m_status),
        .m_item   (m_item),
        .m_count  (m_count),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    sorted_key_table_checker u_check (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_mode   (s_mode),
        .s_key    (s_key),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_status (m_status),
        .m_item   (m_item),
        .m_count  (m_count),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .pready   (pready),
        .pending  (pending),
        .failures (failures)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    initial begin
        #6_000_000;
        $display("[sorted_key_table_unit] ERROR");
        $finish;
    end

    // result side back-pressure, off for the closing phase
    initial begin
        forever begin
            m_ready = 1'b1;
            repeat ($urandom_range(1, 24)) @(negedge aclk);
            if (!calm && $urandom_range(0, 2) == 0) begin
                m_ready = 1'b0;
                repeat ($urandom_range(1, 13)) @(negedge aclk);
            end
        end
    end

    // called at a falling edge; returns at the falling edge after the transaction
    task automatic send_op(input logic [MODE_W-1:0] op, input logic [KEY_WIDTH-1:0] key);
        if (!calm && $urandom_range(0, 3) == 0)
            repeat ($urandom_range(1, 13)) @(negedge aclk);
        s_valid = 1'b1;
        s_mode  = op;
        s_key   = key;
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
        s_valid = 1'b0;
    endtask

    task automatic wait_drained();
        while (pending != 0) @(posedge aclk);
        @(negedge aclk);
    endtask

    task automatic write_order(input logic desc);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = {REG_DESC_ORDER, 2'b00};
        pwdata  = {{(APB_DATA_W-1){1'b0}}, desc};
        @(negedge aclk);
        penable = 1'b1;
        do @(posedge aclk); while (!pready);
        @(negedge aclk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    task automatic refill_pool(input int size);
        int i;
        pool_size = size;
        for (i = 0; i < size; i++) begin
            case ($urandom_range(0, 9))
                0:       key_pool[i] = '0;
                1:       key_pool[i] = '1;
                // close neighbours of the first key
                2:       key_pool[i] = (i == 0) ? $urandom() : key_pool[0] + KEY_WIDTH'(i);
                default: key_pool[i] = $urandom();
            endcase
        end
    endtask

    // removes sometimes name a key that was never inserted
    function automatic logic [KEY_WIDTH-1:0] removal_key();
        if ($urandom_range(0, 5) == 0)
            return $urandom();
        return key_pool[$urandom_range(0, pool_size - 1)];
    endfunction

    task automatic walk_table();
        send_op(MODE_REWIND, $urandom());
        repeat ($urandom_range(2, 18)) send_op(MODE_NEXT, $urandom());
        send_op(MODE_PEEK, $urandom());
    endtask

    task automatic mixed_op();
        case ($urandom_range(0, 15))
            0, 1, 2, 3, 4: send_op(MODE_INSERT, key_pool[$urandom_range(0, pool_size - 1)]);
            5, 6, 7, 8:    send_op(MODE_REMOVE, removal_key());
            9:             send_op(MODE_REWIND, $urandom());
            10, 11, 12:    send_op(MODE_NEXT, $urandom());
            13, 14:        send_op(MODE_PEEK, $urandom());
            default:       send_op(MODE_W'($urandom_range(MODE_SPARE_FIRST, MODE_SPARE_LAST)),
                                   $urandom());
        endcase
    endtask

    task automatic run_phase(input int ph);
        int i;
        wait_drained();
        case (ph)
            0:       write_order(1'b0);
            1:       write_order(1'b1);
            default: write_order(1'($urandom_range(0, 1)));
        endcase
        refill_pool(ph < 2 ? POOL_MAX : $urandom_range(4, POOL_MAX));
        // large pools overflow the table, so the extra inserts meet full and duplicates
        for (i = 0; i < pool_size; i++)
            send_op(MODE_INSERT, key_pool[i]);
        repeat ($urandom_range(2, 8))
            send_op(MODE_INSERT, key_pool[$urandom_range(0, pool_size - 1)]);
        walk_table();
        repeat ($urandom_range(15, 30)) mixed_op();
        // only pool keys go in, so this empties the table
        for (i = 0; i < pool_size; i++)
            send_op(MODE_REMOVE, key_pool[i]);
        repeat ($urandom_range(0, 3)) send_op(MODE_REMOVE, removal_key());
        walk_table();
    endtask

    initial begin
        int           ph;
        logic [MODE_W-1:0] op;
        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // empty table, then edge keys in the reset (largest first) order
        send_op(MODE_PEEK,   32'h0000_0000);
        send_op(MODE_NEXT,   32'hFFFF_FFFF);
        send_op(MODE_REMOVE, 32'h0000_0000);
        send_op(MODE_INSERT, 32'hFFFF_FFFF);
        send_op(MODE_INSERT, 32'h0000_0000);
        send_op(MODE_INSERT, 32'h8000_0000);
        send_op(MODE_INSERT, 32'h8000_0000);
        send_op(MODE_INSERT, 32'h7FFF_FFFF);
        send_op(MODE_REWIND, 32'hA5A5_A5A5);
        send_op(MODE_PEEK,   32'h5A5A_5A5A);
        repeat (5) send_op(MODE_NEXT, 32'h0000_0000);
        send_op(MODE_REMOVE, 32'h8000_0000);
        send_op(MODE_REMOVE, 32'h0000_1234);
        // read position now beyond the shrunken table
        send_op(MODE_PEEK,   32'h0000_0000);
        for (op = MODE_SPARE_FIRST; op != MODE_SPARE_LAST; op++)
            send_op(op, 32'hFFFF_FFFF);
        send_op(MODE_SPARE_LAST, 32'hFFFF_FFFF);
        send_op(MODE_REMOVE, 32'hFFFF_FFFF);
        send_op(MODE_REMOVE, 32'h0000_0000);
        send_op(MODE_REMOVE, 32'h7FFF_FFFF);

        for (ph = 0; ph < PHASES; ph++) begin
            calm = (ph == PHASES - 1);
            run_phase(ph);
        end

        while (pending != 0) @(posedge aclk);
        repeat (4 * CAPACITY + 8) @(posedge aclk);
        if (failures == 0)
            $display("[sorted_key_table_unit] OK");
        else
            $display("[sorted_key_table_unit] ERROR");
        $finish;
    end

endmodule

/* filelist.f */
hdl/skt_pkg.sv
hdl/sorted_key_table_unit.sv
tb/sorted_key_table_checker.sv
tb/tb_sorted_key_table_unit.sv
